FILE: rtl/core/ioc_pkg.sv
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared widths, field positions, codes and types of the I/O request run
// coalescer.
// ----------------------------------------------------------------------------
package ioc_pkg;

    // Field widths of one request and one result.
    localparam int ID_BITS       = 64;
    localparam int SLOT_BITS     = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int OFFSET_BITS   = 64;
    localparam int SIZE_BITS     = 32;

    // Bit positions inside tdata, lowest field first.
    localparam int POS_ID     = 0;
    localparam int POS_RD     = POS_ID + ID_BITS;
    localparam int POS_SLOT   = POS_RD + 1;
    localparam int POS_PRIO   = POS_SLOT + SLOT_BITS;
    localparam int POS_OFFSET = POS_PRIO + PRIORITY_BITS;
    localparam int POS_SIZE   = POS_OFFSET + OFFSET_BITS;
    localparam int FIELD_BITS = POS_SIZE + SIZE_BITS;
    localparam int TDATA_BITS = ((FIELD_BITS + 7) / 8) * 8;
    localparam int PAD_BITS   = TDATA_BITS - FIELD_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_MERGED_BYTES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPORT_ABSORBED  = 2'd1;
    localparam logic [SIZE_BITS-1:0] MAX_MERGED_BYTES_RESET = 32'd131072;
    localparam logic                 REPORT_ABSORBED_RESET  = 1'b1;

    // Result kinds.
    localparam logic KIND_MERGED   = 1'b0;
    localparam logic KIND_ABSORBED = 1'b1;

    // Result queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                     kind;
        logic [ID_BITS-1:0]       id;
        logic                     is_read;
        logic [SLOT_BITS-1:0]     slot;
        logic [PRIORITY_BITS-1:0] priority_cls;
        logic [OFFSET_BITS-1:0]   offset;
        logic [SIZE_BITS-1:0]     size;
        logic                     last;
    } result_t;

    // Results caused by one request: the first always, the second if flagged.
    typedef struct packed {
        logic    r1_valid;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

endpackage

FILE: rtl/core/ioc_front.sv
// ----------------------------------------------------------------------------
// ioc_front
// Accepts requests, decides whether each one folds into the held run, keeps
// the held run and the configuration, and queues the results it causes.
// ----------------------------------------------------------------------------
module ioc_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ioc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ioc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ioc_pkg::TDATA_BITS-1:0]       s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 q_full,
    output ioc_pkg::q_push_t                     push
);

    // Configuration registers.
    logic [ioc_pkg::SIZE_BITS-1:0] max_bytes_reg;
    logic                          report_reg;

    // Held run.
    logic                              held_valid_reg, held_valid_next;
    logic [ioc_pkg::ID_BITS-1:0]       held_id_reg;
    logic                              held_rd_reg;
    logic [ioc_pkg::SLOT_BITS-1:0]     held_slot_reg;
    logic [ioc_pkg::PRIORITY_BITS-1:0] held_prio_reg;
    logic [ioc_pkg::OFFSET_BITS-1:0]   held_offset_reg;
    logic [ioc_pkg::SIZE_BITS-1:0]     held_size_reg, held_size_next;
    logic [ioc_pkg::OFFSET_BITS-1:0]   held_end_reg, held_end_next;

    // Fields of the incoming request.
    logic [ioc_pkg::ID_BITS-1:0]       in_id;
    logic                              in_rd;
    logic [ioc_pkg::SLOT_BITS-1:0]     in_slot;
    logic [ioc_pkg::PRIORITY_BITS-1:0] in_prio;
    logic [ioc_pkg::OFFSET_BITS-1:0]   in_offset;
    logic [ioc_pkg::SIZE_BITS-1:0]     in_size;

    logic                              accept;
    logic                              merge;
    logic [ioc_pkg::SIZE_BITS:0]       size_sum;
    logic                              a_valid;
    ioc_pkg::result_t                  res_a;
    ioc_pkg::result_t                  res_b;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && !q_full;

    assign in_id     = s_tdata[ioc_pkg::POS_ID +: ioc_pkg::ID_BITS];
    assign in_rd     = s_tdata[ioc_pkg::POS_RD];
    assign in_slot   = s_tdata[ioc_pkg::POS_SLOT +: ioc_pkg::SLOT_BITS];
    assign in_prio   = s_tdata[ioc_pkg::POS_PRIO +: ioc_pkg::PRIORITY_BITS];
    assign in_offset = s_tdata[ioc_pkg::POS_OFFSET +: ioc_pkg::OFFSET_BITS];
    assign in_size   = s_tdata[ioc_pkg::POS_SIZE +: ioc_pkg::SIZE_BITS];

    // Configuration writes; indexes outside the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= ioc_pkg::MAX_MERGED_BYTES_RESET;
            report_reg    <= ioc_pkg::REPORT_ABSORBED_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ioc_pkg::CFG_MAX_MERGED_BYTES: begin
                    max_bytes_reg <= cfg_data[ioc_pkg::SIZE_BITS-1:0];
                end
                ioc_pkg::CFG_REPORT_ABSORBED: begin
                    report_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Merge decision. The end of the held run is kept precomputed, so the
    // contiguity test is a plain compare and only the cap test adds.
    assign size_sum = {1'b0, held_size_reg} + {1'b0, in_size};
    assign merge = held_valid_reg
                && (held_rd_reg == in_rd)
                && (held_slot_reg == in_slot)
                && (held_prio_reg == in_prio)
                && (held_end_reg == in_offset)
                && (size_sum <= {1'b0, max_bytes_reg});

    // First candidate result: the absorbed id on a merge, or the displaced
    // held run otherwise. Second candidate: the flush at the end of a batch.
    always_comb begin
        res_a = '0;
        if (merge) begin
            res_a.kind = ioc_pkg::KIND_ABSORBED;
            res_a.id   = in_id;
        end else begin
            res_a.kind         = ioc_pkg::KIND_MERGED;
            res_a.id           = held_id_reg;
            res_a.is_read      = held_rd_reg;
            res_a.slot         = held_slot_reg;
            res_a.priority_cls = held_prio_reg;
            res_a.offset       = held_offset_reg;
            res_a.size         = held_size_reg;
            res_a.last         = 1'b0;
        end

        res_b.kind         = ioc_pkg::KIND_MERGED;
        res_b.id           = merge ? held_id_reg : in_id;
        res_b.is_read      = in_rd;
        res_b.slot         = in_slot;
        res_b.priority_cls = in_prio;
        res_b.offset       = merge ? held_offset_reg : in_offset;
        res_b.size         = merge ? size_sum[ioc_pkg::SIZE_BITS-1:0] : in_size;
        res_b.last         = 1'b1;
    end

    assign a_valid = merge ? report_reg : held_valid_reg;

    // Pack the results of this request into one queue entry.
    always_comb begin
        push.valid          = accept && (a_valid || s_tlast);
        push.entry.r1_valid = a_valid && s_tlast;
        push.entry.r0       = a_valid ? res_a : res_b;
        push.entry.r1       = res_b;
    end

    // Held run update.
    always_comb begin
        held_valid_next = !s_tlast;
        if (merge) begin
            held_size_next = size_sum[ioc_pkg::SIZE_BITS-1:0];
            held_end_next  = held_end_reg + {{(ioc_pkg::OFFSET_BITS -
                                              ioc_pkg::SIZE_BITS){1'b0}}, in_size};
        end else begin
            held_size_next = in_size;
            held_end_next  = in_offset + {{(ioc_pkg::OFFSET_BITS -
                                           ioc_pkg::SIZE_BITS){1'b0}}, in_size};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
        end else if (accept) begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_size_reg <= held_size_next;
            held_end_reg  <= held_end_next;
            if (!merge) begin
                held_id_reg     <= in_id;
                held_rd_reg     <= in_rd;
                held_slot_reg   <= in_slot;
                held_prio_reg   <= in_prio;
                held_offset_reg <= in_offset;
            end
        end
    end

endmodule

FILE: rtl/core/ioc_queue.sv
// ----------------------------------------------------------------------------
// ioc_queue
// Short first-in first-out queue of result entries between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ioc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  ioc_pkg::q_push_t push,
    output logic             full,
    input  logic             pop,
    output ioc_pkg::q_head_t head
);

    ioc_pkg::entry_t                 slots_reg [ioc_pkg::QUEUE_DEPTH];
    logic [ioc_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ioc_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ioc_pkg::QCNT_BITS-1:0]   count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full       = (count_reg == ioc_pkg::QCNT_BITS'(ioc_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slots_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? ioc_pkg::QPTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ioc_pkg::QPTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

FILE: rtl/core/ioc_back.sv
// ----------------------------------------------------------------------------
// ioc_back
// Drains queue entries one result at a time into the output register.
// ----------------------------------------------------------------------------
module ioc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  ioc_pkg::q_head_t head,
    output logic             pop,
    output logic             out_valid,
    output ioc_pkg::result_t out_data,
    input  logic             out_ready
);

    logic             out_valid_reg, out_valid_next;
    ioc_pkg::result_t out_data_reg;
    logic             phase_reg, phase_next;
    logic             load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A new result moves in whenever the output register is free or is
    // being taken in this cycle.
    assign load = head.valid && (!out_valid_reg || out_ready);
    assign pop  = load && (phase_reg || !head.entry.r1_valid);

    always_comb begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (load) begin
            out_valid_next = 1'b1;
            phase_next     = !phase_reg && head.entry.r1_valid;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= phase_reg ? head.entry.r1 : head.entry.r0;
        end
    end

endmodule

FILE: rtl/core/io_request_run_coalescer.sv
// ----------------------------------------------------------------------------
// io_request_run_coalescer
// Folds contiguous storage I/O requests into merged runs and reports the ids
// of the requests it absorbs while absorbed-id reporting is enabled.
// ----------------------------------------------------------------------------
// The results of a taken request beat go into the result queue and reach m_
// through the output register, a second result behind the first.
// Throughput: one request beat per cycle; the output register moves one
// result beat per cycle, so requests that cause two results set the pace.
// The four-entry result queue fills when the output stalls, then s_tready drops.
// Reset: the held run is dropped, the queue empties, registers take defaults.
// ----------------------------------------------------------------------------
module io_request_run_coalescer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ioc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ioc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // Request stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // req_id[63:0], is_read[64], dst_slot[80:65], priority_req[88:81],
    // file_offset[152:89], size[184:153], zero pad[191:185]
    input  logic [ioc_pkg::TDATA_BITS-1:0]       s_tdata,
    input  logic                                 s_tlast,   // batch_last
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_id[63:0], out_is_read[64], out_slot[80:65], out_priority[88:81],
    // out_offset[152:89], out_size[184:153], zero pad[191:185]
    output logic [ioc_pkg::TDATA_BITS-1:0]       m_tdata,
    output logic                                 m_tuser,   // kind
    output logic                                 m_tlast    // out_last
);

    ioc_pkg::q_push_t push;
    ioc_pkg::q_head_t head;
    ioc_pkg::result_t out_data;
    logic             q_full;
    logic             pop;

    ioc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push)
    );

    ioc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .pop     (pop),
        .head    (head)
    );

    ioc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    // Pack the result beat.
    assign m_tdata = {{ioc_pkg::PAD_BITS{1'b0}},
                      out_data.size,
                      out_data.offset,
                      out_data.priority_cls,
                      out_data.slot,
                      out_data.is_read,
                      out_data.id};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule

FILE: tb/tb_io_request_run_coalescer.sv
// ----------------------------------------------------------------------------
// tb_io_request_run_coalescer
// Self-checking testbench for the I/O request run coalescer. A behavioral
// copy of the merge logic predicts every result beat from each accepted
// request beat. A checker compares each result beat field by field with the
// oldest prediction. Directed cases cover the merge rules, register extremes
// and a long output stall. Random phases under several register settings
// then run mostly contiguous runs with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_io_request_run_coalescer;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to wait after the last predicted beat before touching registers.
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [ioc_pkg::ID_BITS-1:0]       id;
        logic                              is_read;
        logic [ioc_pkg::SLOT_BITS-1:0]     slot;
        logic [ioc_pkg::PRIORITY_BITS-1:0] prio;
        logic [ioc_pkg::OFFSET_BITS-1:0]   offset;
        logic [ioc_pkg::SIZE_BITS-1:0]     size;
        logic                              last;
    } io_req_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [ioc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ioc_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [ioc_pkg::TDATA_BITS-1:0]     s_tdata;
    logic                               s_tlast;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [ioc_pkg::TDATA_BITS-1:0]     m_tdata;
    logic                               m_tuser;
    logic                               m_tlast;

    // Mirror of the block's registers and of the open run.
    logic [ioc_pkg::SIZE_BITS-1:0]     cap_bytes     = ioc_pkg::MAX_MERGED_BYTES_RESET;
    logic                              absorb_report = ioc_pkg::REPORT_ABSORBED_RESET;
    logic                              run_valid     = 1'b0;
    logic [ioc_pkg::ID_BITS-1:0]       run_id        = '0;
    logic                              run_is_read   = 1'b0;
    logic [ioc_pkg::SLOT_BITS-1:0]     run_slot      = '0;
    logic [ioc_pkg::PRIORITY_BITS-1:0] run_prio      = '0;
    logic [ioc_pkg::OFFSET_BITS-1:0]   run_offset    = '0;
    logic [ioc_pkg::SIZE_BITS-1:0]     run_size      = '0;

    ioc_pkg::result_t pending_results[$];
    int               mismatch_count = 0;
    logic             idle_enable    = 1'b1;
    int               hold_left      = 0;

    // Last random request, used to build contiguous follow-ups.
    io_req_t prev_req;
    logic    have_prev = 1'b0;

    io_request_run_coalescer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    // Appends one predicted result beat to the tail of the queue.
    function automatic void queue_result(input ioc_pkg::result_t res);
        pending_results = {pending_results, res};
    endfunction

    function automatic io_req_t make_req(input logic [ioc_pkg::ID_BITS-1:0] id,
                                         input logic is_read,
                                         input logic [ioc_pkg::SLOT_BITS-1:0] slot,
                                         input logic [ioc_pkg::PRIORITY_BITS-1:0] prio,
                                         input logic [ioc_pkg::OFFSET_BITS-1:0] offset,
                                         input logic [ioc_pkg::SIZE_BITS-1:0] size,
                                         input logic last);
        io_req_t r;
        r.id      = id;
        r.is_read = is_read;
        r.slot    = slot;
        r.prio    = prio;
        r.offset  = offset;
        r.size    = size;
        r.last    = last;
        return r;
    endfunction

    // The open run as a merged result beat.
    function automatic ioc_pkg::result_t run_result(input logic ends_batch);
        ioc_pkg::result_t res;
        res.kind         = ioc_pkg::KIND_MERGED;
        res.id           = run_id;
        res.is_read      = run_is_read;
        res.slot         = run_slot;
        res.priority_cls = run_prio;
        res.offset       = run_offset;
        res.size         = run_size;
        res.last         = ends_batch;
        return res;
    endfunction

    // Folds one request into the mirrored run and queues the beats it causes.
    function automatic void coalesce_predict(input io_req_t r);
        logic [ioc_pkg::SIZE_BITS:0]     grown;
        logic [ioc_pkg::OFFSET_BITS-1:0] run_end;
        logic                            joins;
        ioc_pkg::result_t                absorbed;
        grown   = {1'b0, run_size} + {1'b0, r.size};
        run_end = run_offset + ioc_pkg::OFFSET_BITS'(run_size);
        joins   = run_valid && (run_is_read == r.is_read) && (run_slot == r.slot)
               && (run_prio == r.prio) && (run_end == r.offset)
               && (grown <= {1'b0, cap_bytes});
        if (joins) begin
            run_size = grown[ioc_pkg::SIZE_BITS-1:0];
            if (absorb_report) begin
                absorbed              = '0;
                absorbed.kind         = ioc_pkg::KIND_ABSORBED;
                absorbed.id           = r.id;
                queue_result(absorbed);
            end
        end else begin
            if (run_valid)
                queue_result(run_result(1'b0));
            run_valid   = 1'b1;
            run_id      = r.id;
            run_is_read = r.is_read;
            run_slot    = r.slot;
            run_prio    = r.prio;
            run_offset  = r.offset;
            run_size    = r.size;
        end
        if (r.last) begin
            queue_result(run_result(1'b1));
            run_valid = 1'b0;
        end
    endfunction

    // Offers one request beat from a falling edge and returns at the falling
    // edge after it is taken; valid stays up for a following beat.
    task automatic send_request(input io_req_t r);
        logic [ioc_pkg::TDATA_BITS-1:0] beat;
        beat = '0;
        beat[ioc_pkg::POS_ID     +: ioc_pkg::ID_BITS]       = r.id;
        beat[ioc_pkg::POS_RD]                               = r.is_read;
        beat[ioc_pkg::POS_SLOT   +: ioc_pkg::SLOT_BITS]     = r.slot;
        beat[ioc_pkg::POS_PRIO   +: ioc_pkg::PRIORITY_BITS] = r.prio;
        beat[ioc_pkg::POS_OFFSET +: ioc_pkg::OFFSET_BITS]   = r.offset;
        beat[ioc_pkg::POS_SIZE   +: ioc_pkg::SIZE_BITS]     = r.size;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tlast  <= r.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        coalesce_predict(r);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every predicted beat has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes one register through the configuration channel.
    task automatic write_register(input logic [ioc_pkg::CFG_INDEX_BITS-1:0] index,
                                  input logic [ioc_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (index == ioc_pkg::CFG_MAX_MERGED_BYTES)
            cap_bytes = value[ioc_pkg::SIZE_BITS-1:0];
        else if (index == ioc_pkg::CFG_REPORT_ABSORBED)
            absorb_report = value[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_registers(input logic [ioc_pkg::SIZE_BITS-1:0] cap,
                                 input logic report);
        drain_results();
        write_register(ioc_pkg::CFG_MAX_MERGED_BYTES, cap);
        write_register(ioc_pkg::CFG_REPORT_ABSORBED, ioc_pkg::CFG_DATA_BITS'(report));
    endtask

    // Random request: mostly contiguous follow-ups, some broken, some noise.
    task automatic send_random_request();
        io_req_t          r;
        int               pick;
        logic [31:0]      small_max;
        small_max = (cap_bytes >= 32'd65536) ? 32'd16384 : cap_bytes / 4;
        r.id = {$urandom, $urandom};
        if (have_prev && $urandom_range(0, 9) < 7) begin
            r.is_read = prev_req.is_read;
            r.slot    = prev_req.slot;
            r.prio    = prev_req.prio;
            r.offset  = prev_req.offset + ioc_pkg::OFFSET_BITS'(prev_req.size);
            // Break one merge condition now and then.
            case ($urandom_range(0, 11))
                0: r.is_read = ~r.is_read;
                1: r.slot    = r.slot ^ ioc_pkg::SLOT_BITS'($urandom_range(1, 65535));
                2: r.prio    = r.prio ^ ioc_pkg::PRIORITY_BITS'($urandom_range(1, 255));
                3: r.offset  = r.offset + ioc_pkg::OFFSET_BITS'($urandom_range(1, 512));
                default: ;
            endcase
        end else begin
            r.is_read = 1'($urandom_range(0, 1));
            r.slot    = ($urandom_range(0, 3) == 0)
                      ? ioc_pkg::SLOT_BITS'($urandom)
                      : ioc_pkg::SLOT_BITS'($urandom_range(0, 3));
            r.prio    = ($urandom_range(0, 3) == 0)
                      ? ioc_pkg::PRIORITY_BITS'($urandom)
                      : ioc_pkg::PRIORITY_BITS'($urandom_range(0, 3));
            r.offset  = ($urandom_range(0, 1) == 0)
                      ? {$urandom, $urandom}
                      : ioc_pkg::OFFSET_BITS'($urandom_range(0, 65535));
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0:       r.size = '0;
            6:       r.size = $urandom_range(cap_bytes / 2, cap_bytes);
            7:       r.size = $urandom;
            8, 9:    r.size = $urandom_range(1, 4096);
            default: r.size = $urandom_range(0, small_max);
        endcase
        r.last    = ($urandom_range(0, 11) == 0);
        prev_req  = r;
        have_prev = 1'b1;
        send_request(r);
    endtask

    // Merge rules under the reset register values.
    task automatic test_directed_merge();
        logic [ioc_pkg::OFFSET_BITS-1:0] near_top;
        near_top = '1 - 64'd15;
        // A contiguous run with absorbed ids, closed by a last request.
        send_request(make_req('1, 1'b1, '1, '1, 64'd0, 32'd4096, 1'b0));
        send_request(make_req(64'h11, 1'b1, '1, '1, 64'd4096, 32'd4096, 1'b0));
        send_request(make_req(64'h12, 1'b1, '1, '1, 64'd8192, 32'd8192, 1'b1));
        // The offset sum wraps, and a zero size still merges.
        send_request(make_req(64'h20, 1'b0, '0, '0, near_top, 32'd16, 1'b0));
        send_request(make_req(64'h21, 1'b0, '0, '0, 64'd0, 32'd0, 1'b0));
        // Each field that must match breaks the run on its own.
        send_request(make_req(64'h22, 1'b0, 16'd1, '0, 64'd0, 32'd16, 1'b0));
        send_request(make_req(64'h23, 1'b0, 16'd1, 8'd1, 64'd16, 32'd16, 1'b0));
        send_request(make_req(64'h24, 1'b1, 16'd1, 8'd1, 64'd32, 32'd16, 1'b0));
        send_request(make_req(64'h25, 1'b1, 16'd1, 8'd1, 64'd49, 32'd100, 1'b0));
        // Filling the cap exactly merges; one byte more does not.
        send_request(make_req(64'h26, 1'b1, 16'd1, 8'd1, 64'd149,
                              ioc_pkg::MAX_MERGED_BYTES_RESET - 32'd100, 1'b0));
        send_request(make_req(64'h27, 1'b1, 16'd1, 8'd1,
                              64'd49 + 64'(ioc_pkg::MAX_MERGED_BYTES_RESET), 32'd1, 1'b1));
        // An oversized lone request goes out unmerged.
        send_request(make_req(64'h28, 1'b0, 16'h8000, 8'h80, 64'h1000, '1, 1'b0));
        send_request(make_req(64'h29, 1'b0, 16'h8000, 8'h80, 64'h1000 + 64'hFFFF_FFFF,
                              32'd0, 1'b1));
    endtask

    // Register extremes: zero cap, full cap, reporting off and on.
    task automatic test_register_extremes();
        set_registers(32'd0, 1'b0);
        send_request(make_req(64'h30, 1'b0, 16'd5, 8'd5, 64'd500, 32'd0, 1'b0));
        send_request(make_req(64'h31, 1'b0, 16'd5, 8'd5, 64'd500, 32'd0, 1'b0));
        send_request(make_req(64'h32, 1'b0, 16'd5, 8'd5, 64'd500, 32'd1, 1'b1));
        set_registers('1, 1'b1);
        send_request(make_req(64'h40, 1'b1, 16'd7, 8'd7, 64'h8000_0000_0000_0000, '1, 1'b0));
        send_request(make_req(64'h41, 1'b1, 16'd7, 8'd7, 64'h8000_0000_FFFF_FFFF, 32'd0,
                              1'b0));
        send_request(make_req(64'h42, 1'b1, 16'd7, 8'd7, 64'h8000_0000_FFFF_FFFF, 32'd1,
                              1'b1));
        set_registers(32'd0, 1'b1);
        send_request(make_req(64'h50, 1'b0, 16'd9, 8'd9, 64'd0, 32'd5, 1'b1));
    endtask

    // The receiver holds off for a long time while requests keep coming.
    task automatic test_output_backpressure();
        set_registers(ioc_pkg::MAX_MERGED_BYTES_RESET, 1'b1);
        hold_left = 300;
        for (int i = 0; i < 24; i++)
            send_request(make_req({$urandom, $urandom}, i[0], ioc_pkg::SLOT_BITS'(i),
                                  ioc_pkg::PRIORITY_BITS'(i), 64'(i) * 64'h1000 + 64'h7,
                                  32'd100, (i % 2) == 1));
    endtask

    // Random traffic under several register settings.
    task automatic test_random_traffic();
        logic [ioc_pkg::SIZE_BITS-1:0] caps[5];
        logic                          reports[5];
        caps    = '{ioc_pkg::MAX_MERGED_BYTES_RESET, 32'd4096, 32'd0, '1, $urandom};
        reports = '{1'b1, 1'b0, 1'b1, 1'b1, 1'($urandom_range(0, 1))};
        for (int p = 0; p < 5; p++) begin
            set_registers(caps[p], reports[p]);
            repeat (240) send_random_request();
        end
    endtask

    // Closing phase with no idling on either side.
    task automatic test_steady_stream();
        set_registers(32'd65536, 1'b1);
        idle_enable = 1'b0;
        repeat (200) send_random_request();
        send_request(make_req({$urandom, $urandom}, 1'b0, '0, '0, '0, 32'd1, 1'b1));
    endtask

    // Result ready: long hold-off first, then random stall bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compares each result beat with the oldest prediction.
    always @(posedge aclk) begin
        ioc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat id",
                                m_tdata[ioc_pkg::POS_ID +: ioc_pkg::ID_BITS], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
                if (m_tdata[ioc_pkg::POS_ID +: ioc_pkg::ID_BITS] !== want.id)
                    report_mismatch("out_id", m_tdata[ioc_pkg::POS_ID +: ioc_pkg::ID_BITS],
                                    want.id);
                if (m_tdata[ioc_pkg::POS_RD] !== want.is_read)
                    report_mismatch("out_is_read", 64'(m_tdata[ioc_pkg::POS_RD]),
                                    64'(want.is_read));
                if (m_tdata[ioc_pkg::POS_SLOT +: ioc_pkg::SLOT_BITS] !== want.slot)
                    report_mismatch("out_slot",
                                    64'(m_tdata[ioc_pkg::POS_SLOT +: ioc_pkg::SLOT_BITS]),
                                    64'(want.slot));
                if (m_tdata[ioc_pkg::POS_PRIO +: ioc_pkg::PRIORITY_BITS] !== want.priority_cls)
                    report_mismatch("out_priority",
                                    64'(m_tdata[ioc_pkg::POS_PRIO +: ioc_pkg::PRIORITY_BITS]),
                                    64'(want.priority_cls));
                if (m_tdata[ioc_pkg::POS_OFFSET +: ioc_pkg::OFFSET_BITS] !== want.offset)
                    report_mismatch("out_offset",
                                    m_tdata[ioc_pkg::POS_OFFSET +: ioc_pkg::OFFSET_BITS],
                                    want.offset);
                if (m_tdata[ioc_pkg::POS_SIZE +: ioc_pkg::SIZE_BITS] !== want.size)
                    report_mismatch("out_size",
                                    64'(m_tdata[ioc_pkg::POS_SIZE +: ioc_pkg::SIZE_BITS]),
                                    64'(want.size));
                if (m_tlast !== want.last)
                    report_mismatch("out_last", 64'(m_tlast), 64'(want.last));
                if (m_tdata[ioc_pkg::TDATA_BITS-1 -: ioc_pkg::PAD_BITS] !== '0)
                    report_mismatch("tdata pad",
                                    64'(m_tdata[ioc_pkg::TDATA_BITS-1 -: ioc_pkg::PAD_BITS]),
                                    '0);
            end
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_merge();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();
        test_steady_stream();
        drain_results();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
